// ----- design/ruf_pkg.sv -----
package ruf_pkg;

   localparam int MAX_PAYLOAD_DEF = 15;

   localparam int BYTE_W     = 8;
   localparam int FD_W       = 3;
   localparam int VAL_W      = 17;
   localparam int ST_W       = 3;
   localparam int INT_W      = 32;
   localparam int FRAC_W     = 14;
   localparam int CSR_ADDR_W = 3;
   localparam int RSP_W      = 24;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_UP_N  = 8'h4E;
   localparam logic [BYTE_W-1:0] CH_LO_N  = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRACTION_DIGITS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_VALUE       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_VALUE       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NA_ALLOWED      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_POST_MODE       = 3'd4;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_NA     = 3'd1,
      ST_FRAME  = 3'd2,
      ST_SYNTAX = 3'd3,
      ST_RANGE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_AFTER_SIGN,
      PH_INT,
      PH_AFTER_POINT,
      PH_FRAC,
      PH_COLON
   } phase_type;

   typedef enum logic [2:0] {
      NA_IDLE,
      NA_N,
      NA_NA,
      NA_N_SLASH,
      NA_N_SLASH_A,
      NA_NONE
   } na_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_INT,
      MODE_MINSEC,
      MODE_KELVIN
   } post_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_FIN1,
      S_FIN2,
      S_FIN3
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic fin1;
      logic fin2;
      logic finish;
   } dp_cmd_type;

   function automatic logic [FRAC_W-1:0] pow10(input logic [FD_W-1:0] n);
      logic [FRAC_W-1:0] r;
      case (n)
         3'd0:    r = 14'd1;
         3'd1:    r = 14'd10;
         3'd2:    r = 14'd100;
         3'd3:    r = 14'd1000;
         default: r = 14'd10000;
      endcase
      return r;
   endfunction

   // largest integer part whose scaled value still fits in 31 bits
   function automatic logic [INT_W-1:0] int_limit(input logic [FD_W-1:0] n);
      logic [INT_W-1:0] r;
      case (n)
         3'd0:    r = 32'd2147483647;
         3'd1:    r = 32'd214748364;
         3'd2:    r = 32'd21474836;
         3'd3:    r = 32'd2147483;
         default: r = 32'd214748;
      endcase
      return r;
   endfunction

endpackage

// ----- design/ruf_ctrl.sv -----
module ruf_ctrl import ruf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_STEP;
         S_STEP: state_in = last_ff ? S_FIN1 : S_IDLE;
         S_FIN1: state_in = S_FIN2;
         S_FIN2: state_in = S_FIN3;
         S_FIN3: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_STEP: cmd.step = 1'b1;
         S_FIN1: cmd.fin1 = 1'b1;
         S_FIN2: cmd.fin2 = 1'b1;
         S_FIN3: cmd.finish = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      last_in = cmd.capture ? req_tlast : last_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- design/ruf_dp.sv -----
module ruf_dp import ruf_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [BYTE_W-1:0]     req_byte,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [VAL_W-1:0]      csr_wdata,
   output logic [RSP_W-1:0]      rsp_word
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   // configuration
   logic [FD_W-1:0]         fd_ff, fd_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [VAL_W-1:0] max_ff, max_in;
   logic                    na_en_ff, na_en_in;
   post_mode_type           mode_ff, mode_in;

   // reply state
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [2*BYTE_W-1:0] win_ff, win_in;
   logic [1:0]          fill_ff, fill_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   phase_type           phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [INT_W-1:0]    int_ff, int_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [FD_W-1:0]     fcnt_ff, fcnt_in;
   na_type              na_ff, na_in;
   status_type          err_ff, err_in;

   // finish pipeline
   logic [INT_W-1:0]        prod_ff, prod_in;
   logic [FRAC_W-1:0]       fracs_ff, fracs_in;
   logic signed [INT_W:0]   scaled_ff, scaled_in;
   logic [RSP_W-1:0]        out_ff, out_in;

   logic [FD_W-1:0]         fd;
   logic [BYTE_W-1:0]       ch;
   logic                    is_digit, printable, is_n, is_a, phase_open;
   logic [3:0]              dig;
   logic [INT_W+3:0]        int_sum;
   logic                    int_over;
   logic [FRAC_W+3:0]       frac_sum;
   na_type                  na_next;
   logic [INT_W+FRAC_W-1:0] prod_full;
   logic [2*FRAC_W-1:0]     fracs_full;
   logic [INT_W:0]          sum_ext;
   logic signed [VAL_W-1:0] s17;
   logic signed [VAL_W:0]   int_val;
   logic signed [23:0]      s24, min_sec;
   logic signed [VAL_W:0]   kelvin;
   logic [VAL_W-1:0]        post_val;
   logic                    out_of_range;
   status_type              fin_st;

   assign fd         = (fd_ff > 3'd4) ? 3'd4 : fd_ff;
   assign ch         = win_ff[2*BYTE_W-1:BYTE_W];
   assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign printable  = (ch >= CH_SPACE) && (ch <= CH_TILDE);
   assign is_n       = (ch == CH_UP_N) || (ch == CH_LO_N);
   assign is_a       = (ch == CH_UP_A) || (ch == CH_LO_A);
   assign dig        = ch[3:0];
   assign phase_open = (phase_ff == PH_START) || (phase_ff == PH_AFTER_SIGN) ||
                       (phase_ff == PH_AFTER_POINT);

   assign int_sum  = ({4'b0, int_ff} << 3) + ({4'b0, int_ff} << 1) + {32'b0, dig};
   assign int_over = int_sum > {4'b0, int_limit(fd)};
   assign frac_sum = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1) + {14'b0, dig};

   always_comb begin
      case (na_ff)
         NA_IDLE:    na_next = is_n ? NA_N : NA_NONE;
         NA_N:       na_next = is_a ? NA_NA : ((ch == CH_SLASH) ? NA_N_SLASH : NA_NONE);
         NA_N_SLASH: na_next = is_a ? NA_N_SLASH_A : NA_NONE;
         default:    na_next = NA_NONE;
      endcase
   end

   // configuration writes
   always_comb begin
      fd_in    = fd_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      na_en_in = na_en_ff;
      mode_in  = mode_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FRACTION_DIGITS: fd_in    = csr_wdata[FD_W-1:0];
            CSR_MIN_VALUE:       min_in   = csr_wdata;
            CSR_MAX_VALUE:       max_in   = csr_wdata;
            CSR_NA_ALLOWED:      na_en_in = csr_wdata[0];
            CSR_POST_MODE:       mode_in  = post_mode_type'(csr_wdata[1:0]);
            default:             fd_in    = fd_ff;
         endcase
      end
   end

   // byte parse step on the oldest byte of the window; finish clears the reply state
   always_comb begin
      byte_in  = cmd.capture ? req_byte : byte_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      na_in    = na_ff;
      err_in   = err_ff;
      if (cmd.finish) begin
         win_in   = '0;
         fill_in  = '0;
         cnt_in   = '0;
         phase_in = PH_START;
         neg_in   = 1'b0;
         int_in   = '0;
         frac_in  = '0;
         fcnt_in  = '0;
         na_in    = NA_IDLE;
         err_in   = ST_OK;
      end else if (cmd.step) begin
         win_in  = {win_ff[BYTE_W-1:0], byte_ff};
         fill_in = (fill_ff == 2'd2) ? 2'd2 : fill_ff + 2'd1;
         if (fill_ff == 2'd2) begin
            if (cnt_ff <= CNT_MAX) cnt_in = cnt_ff + 1'b1;
            if (!printable) begin
               err_in = ST_FRAME;
            end else begin
               na_in = na_next;
               if (phase_ff == PH_COLON) begin
                  phase_in = PH_COLON;
               end else if (mode_ff == MODE_MINSEC && ch == CH_COLON) begin
                  if (phase_open && err_ff == ST_OK) err_in = ST_SYNTAX;
                  phase_in = PH_COLON;
               end else if (err_ff == ST_OK) begin
                  case (phase_ff) inside
                     PH_START: begin
                        if (ch == CH_MINUS) begin
                           neg_in   = 1'b1;
                           phase_in = PH_AFTER_SIGN;
                        end else if (ch == CH_PLUS) begin
                           phase_in = PH_AFTER_SIGN;
                        end else if (is_digit) begin
                           if (int_over) err_in = ST_RANGE;
                           else int_in = int_sum[INT_W-1:0];
                           phase_in = PH_INT;
                        end else begin
                           err_in = ST_SYNTAX;
                        end
                     end
                     PH_AFTER_SIGN: begin
                        if (is_digit) begin
                           if (int_over) err_in = ST_RANGE;
                           else int_in = int_sum[INT_W-1:0];
                           phase_in = PH_INT;
                        end else begin
                           err_in = ST_SYNTAX;
                        end
                     end
                     PH_INT: begin
                        if (is_digit) begin
                           if (int_over) err_in = ST_RANGE;
                           else int_in = int_sum[INT_W-1:0];
                        end else if (ch == CH_POINT) begin
                           phase_in = PH_AFTER_POINT;
                        end else begin
                           err_in = ST_SYNTAX;
                        end
                     end
                     PH_AFTER_POINT, PH_FRAC: begin
                        if (is_digit) begin
                           if (fcnt_ff < fd) begin
                              frac_in = frac_sum[FRAC_W-1:0];
                              fcnt_in = fcnt_ff + 3'd1;
                           end
                           phase_in = PH_FRAC;
                        end else begin
                           err_in = ST_SYNTAX;
                        end
                     end
                     default: err_in = ST_SYNTAX;
                  endcase
               end
            end
         end
      end
   end

   // finish: scale, sign, range check and post step
   assign prod_full  = int_ff * pow10(fd);
   assign fracs_full = frac_ff * pow10(fd - fcnt_ff);
   assign prod_in    = cmd.fin1 ? prod_full[INT_W-1:0] : prod_ff;
   assign fracs_in   = cmd.fin1 ? fracs_full[FRAC_W-1:0] : fracs_ff;
   assign sum_ext    = {1'b0, prod_ff} + {19'b0, fracs_ff};
   assign scaled_in  = cmd.fin2 ? (neg_ff ? -$signed(sum_ext) : $signed(sum_ext)) : scaled_ff;

   assign out_of_range = (scaled_ff < $signed({{16{min_ff[VAL_W-1]}}, min_ff})) ||
                         (scaled_ff > $signed({{16{max_ff[VAL_W-1]}}, max_ff}));

   assign s17     = scaled_ff[VAL_W-1:0];
   assign int_val = neg_ff ? -$signed({1'b0, int_ff[VAL_W-1:0]})
                           : $signed({1'b0, int_ff[VAL_W-1:0]});
   assign s24     = {{7{s17[VAL_W-1]}}, s17};
   assign min_sec = (s24 <<< 6) - (s24 <<< 2);
   assign kelvin  = {s17[VAL_W-1], s17} + 18'sd2731;

   always_comb begin
      case (mode_ff)
         MODE_INT: post_val = int_val[VAL_W-1:0];
         MODE_MINSEC: begin
            if (min_sec > 24'sd65535)       post_val = 17'h0FFFF;
            else if (min_sec < -24'sd65536) post_val = 17'h10000;
            else                            post_val = min_sec[VAL_W-1:0];
         end
         MODE_KELVIN: begin
            if (kelvin < 18'sd0)          post_val = '0;
            else if (kelvin > 18'sd65535) post_val = 17'h0FFFF;
            else                          post_val = kelvin[VAL_W-1:0];
         end
         default: post_val = s17;
      endcase
   end

   always_comb begin
      if (fill_ff != 2'd2 || win_ff != {CH_CR, CH_LF}) begin
         fin_st = ST_FRAME;
      end else if (cnt_ff == '0 || cnt_ff > CNT_MAX) begin
         fin_st = ST_FRAME;
      end else if (err_ff == ST_FRAME) begin
         fin_st = ST_FRAME;
      end else if (na_en_ff && (na_ff == NA_NA || na_ff == NA_N_SLASH_A)) begin
         fin_st = ST_NA;
      end else if (mode_ff == MODE_MINSEC && phase_ff != PH_COLON) begin
         fin_st = ST_SYNTAX;
      end else if (err_ff != ST_OK) begin
         fin_st = err_ff;
      end else if (phase_open) begin
         fin_st = ST_SYNTAX;
      end else if (out_of_range) begin
         fin_st = ST_RANGE;
      end else begin
         fin_st = ST_OK;
      end
   end

   assign out_in = cmd.finish
      ? {4'b0, ((fin_st == ST_OK) ? post_val : {VAL_W{1'b0}}), fin_st}
      : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fd_ff    <= 3'd2;
         min_ff   <= '0;
         max_ff   <= 17'sd65535;
         na_en_ff <= 1'b1;
         mode_ff  <= MODE_NONE;
         win_ff   <= '0;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         phase_ff <= PH_START;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
         na_ff    <= NA_IDLE;
         err_ff   <= ST_OK;
      end else begin
         fd_ff    <= fd_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         na_en_ff <= na_en_in;
         mode_ff  <= mode_in;
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         na_ff    <= na_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      prod_ff   <= prod_in;
      fracs_ff  <= fracs_in;
      scaled_ff <= scaled_in;
      out_ff    <= out_in;
   end

   assign rsp_word = out_ff;

endmodule

// ----- design/reply_decimal_field_parser_unit.sv -----
// Each reply word is accepted, then one parse step runs on the window's oldest byte.
// A word with tlast then runs FIN1 (scale multiply), FIN2 (sign) and FIN3 (range, post step);
// rsp_tvalid is registered from FIN3, and no new word is taken until FIN3 completes.
// A result waiting in the output register stalls only the next finishing word.
// Synchronous active-high reset restores register defaults and clears all parse state.
module reply_decimal_field_parser_unit import ruf_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] reply_byte
   input  logic                  req_tlast,   // reply_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // [2:0] status, [19:3] value, [23:20] zero
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [VAL_W-1:0]      csr_wdata
);

   dp_cmd_type cmd;

   ruf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ruf_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_byte  (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_tdata)
   );

endmodule

// ----- design/ruf_checker.sv -----
module ruf_checker import ruf_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again during parse step");

   a_no_result_midreply: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result without reply end");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_RANGE && rsp_tdata[RSP_W-1:20] == '0)
      else $error("bad status code or padding");

   a_value_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[19:3] == '0)
      else $error("nonzero value with error status");

endmodule

bind reply_decimal_field_parser_unit ruf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/reply_field_checker.sv -----
module reply_field_checker import ruf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [VAL_W-1:0]      csr_wdata,
   output int                    replies_in_flight,
   output int                    mismatches,
   output int                    checked
);

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] value;
   } parsed_reply_type;

   parsed_reply_type predicted_replies[$];

   logic [FD_W-1:0]         cfg_frac_digits;
   logic signed [VAL_W-1:0] cfg_min;
   logic signed [VAL_W-1:0] cfg_max;
   logic                    cfg_na_ok;
   post_mode_type           cfg_mode;

   logic [15:0]       window;
   logic [1:0]        fill;
   logic [4:0]        chars;
   phase_type         phase;
   logic              neg;
   logic [INT_W-1:0]  int_acc;
   logic [FRAC_W-1:0] frac_acc;
   logic [FD_W-1:0]   frac_cnt;
   na_type            na;
   status_type        err;

   function automatic int kept_digits();
      return (cfg_frac_digits > 4) ? 4 : int'(cfg_frac_digits);
   endfunction

   function automatic longint decimal_scale(input int n);
      longint p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   task automatic clear_reply_state();
      window   = '0;
      fill     = '0;
      chars    = '0;
      phase    = PH_START;
      neg      = 1'b0;
      int_acc  = '0;
      frac_acc = '0;
      frac_cnt = '0;
      na       = NA_IDLE;
      err      = ST_OK;
   endtask

   task automatic note_error(input status_type code);
      if (err == ST_OK) err = code;
   endtask

   task automatic push_int_digit(input int d);
      longint acc;
      longint lim;
      acc = longint'({32'd0, int_acc}) * 10 + d;
      lim = 2147483647 / decimal_scale(kept_digits());
      if (acc > lim) begin
         note_error(ST_RANGE);
      end else begin
         int_acc = acc[INT_W-1:0];
      end
   endtask

   task automatic push_frac_digit(input int d);
      if (frac_cnt < kept_digits()) begin
         frac_acc = FRAC_W'(frac_acc * 10 + d);
         frac_cnt = frac_cnt + 1'b1;
      end
   endtask

   task automatic parse_payload_byte(input logic [7:0] c);
      logic is_n;
      logic is_a;
      logic digit;
      int   d;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d = int'(c) - int'(CH_ZERO);
      is_n = (c == CH_UP_N) || (c == CH_LO_N);
      is_a = (c == CH_UP_A) || (c == CH_LO_A);
      if (chars <= MAX_PAYLOAD_DEF) chars = chars + 1'b1;
      if (c < CH_SPACE || c > CH_TILDE) begin
         err = ST_FRAME;
         return;
      end
      case (na)
         NA_IDLE:    na = is_n ? NA_N : NA_NONE;
         NA_N:       na = is_a ? NA_NA : ((c == CH_SLASH) ? NA_N_SLASH : NA_NONE);
         NA_N_SLASH: na = is_a ? NA_N_SLASH_A : NA_NONE;
         default:    na = NA_NONE;
      endcase
      if (phase == PH_COLON) return;
      if (cfg_mode == MODE_MINSEC && c == CH_COLON) begin
         if (phase == PH_START || phase == PH_AFTER_SIGN || phase == PH_AFTER_POINT)
            note_error(ST_SYNTAX);
         phase = PH_COLON;
         return;
      end
      if (err != ST_OK) return;
      case (phase)
         PH_START: begin
            if (c == CH_MINUS) begin
               neg = 1'b1;
               phase = PH_AFTER_SIGN;
            end else if (c == CH_PLUS) begin
               phase = PH_AFTER_SIGN;
            end else if (digit) begin
               push_int_digit(d);
               phase = PH_INT;
            end else begin
               note_error(ST_SYNTAX);
            end
         end
         PH_AFTER_SIGN: begin
            if (digit) begin
               push_int_digit(d);
               phase = PH_INT;
            end else begin
               note_error(ST_SYNTAX);
            end
         end
         PH_INT: begin
            if (digit) push_int_digit(d);
            else if (c == CH_POINT) phase = PH_AFTER_POINT;
            else note_error(ST_SYNTAX);
         end
         PH_AFTER_POINT: begin
            if (digit) begin
               push_frac_digit(d);
               phase = PH_FRAC;
            end else begin
               note_error(ST_SYNTAX);
            end
         end
         PH_FRAC: begin
            if (digit) push_frac_digit(d);
            else note_error(ST_SYNTAX);
         end
         default: note_error(ST_SYNTAX);
      endcase
   endtask

   function automatic parsed_reply_type conclude_reply();
      parsed_reply_type r;
      int               fd;
      int               k;
      longint           frac;
      longint           scaled;
      longint           v;
      fd = kept_digits();
      r.status = ST_OK;
      r.value = '0;
      if (fill < 2 || window != {CH_CR, CH_LF}) r.status = ST_FRAME;
      else if (chars == 0 || chars > MAX_PAYLOAD_DEF) r.status = ST_FRAME;
      else if (err == ST_FRAME) r.status = ST_FRAME;
      else if (cfg_na_ok && (na == NA_NA || na == NA_N_SLASH_A)) r.status = ST_NA;
      else if (cfg_mode == MODE_MINSEC && phase != PH_COLON) r.status = ST_SYNTAX;
      else if (err != ST_OK) r.status = err;
      else if (phase == PH_START || phase == PH_AFTER_SIGN || phase == PH_AFTER_POINT)
         r.status = ST_SYNTAX;
      if (r.status != ST_OK) return r;

      frac = longint'({50'd0, frac_acc});
      for (k = int'(frac_cnt); k < fd; k++) frac = frac * 10;
      scaled = longint'({32'd0, int_acc}) * decimal_scale(fd) + frac;
      if (neg) scaled = -scaled;
      if (scaled < cfg_min || scaled > cfg_max) begin
         r.status = ST_RANGE;
         return r;
      end
      case (cfg_mode)
         MODE_INT: v = scaled / decimal_scale(fd);
         MODE_MINSEC: begin
            v = scaled * 60;
            if (v > 65535) v = 65535;
            if (v < -65536) v = -65536;
         end
         MODE_KELVIN: begin
            v = scaled + 2731;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
         end
         default: v = scaled;
      endcase
      r.value = v[VAL_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      parsed_reply_type want;
      status_type       got_status;
      logic [VAL_W-1:0] got_value;
      logic [RSP_W-ST_W-VAL_W-1:0] got_pad;
      if (reset) begin
         cfg_frac_digits = 3'd2;
         cfg_min = '0;
         cfg_max = 17'sd65535;
         cfg_na_ok = 1'b1;
         cfg_mode = MODE_NONE;
         clear_reply_state();
         predicted_replies.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_FRACTION_DIGITS: cfg_frac_digits = csr_wdata[FD_W-1:0];
               CSR_MIN_VALUE:       cfg_min = csr_wdata;
               CSR_MAX_VALUE:       cfg_max = csr_wdata;
               CSR_NA_ALLOWED:      cfg_na_ok = csr_wdata[0];
               CSR_POST_MODE:       cfg_mode = post_mode_type'(csr_wdata[1:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (fill >= 2) parse_payload_byte(window[15:8]);
            window = {window[7:0], req_tdata};
            if (fill < 2) fill = fill + 1'b1;
            if (req_tlast) begin
               predicted_replies.push_back(conclude_reply());
               clear_reply_state();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = status_type'(rsp_tdata[ST_W-1:0]);
            got_value  = rsp_tdata[ST_W+VAL_W-1:ST_W];
            got_pad    = rsp_tdata[RSP_W-1:ST_W+VAL_W];
            checked++;
            if (predicted_replies.size() == 0) begin
               $error("result with no reply pending: status %0d value %0d",
                      got_status, got_value);
               mismatches++;
            end else begin
               want = predicted_replies.pop_front();
               if (got_status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got_status);
                  mismatches++;
               end
               if (got_value != want.value) begin
                  $error("value: expected %0d, got %0d",
                         $signed(want.value), $signed(got_value));
                  mismatches++;
               end
               if (got_pad != '0) begin
                  $error("pad: expected 0, got %0h", got_pad);
                  mismatches++;
               end
            end
         end
      end
      replies_in_flight <= predicted_replies.size();
   end

endmodule

// ----- verif/testbench.sv -----
module testbench;
   import ruf_pkg::*;

   localparam int WORD_TARGET   = 850;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 10;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [VAL_W-1:0]      csr_wdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_W-1:0]      rsp_tdata;

   int replies_in_flight;
   int mismatches;
   int checked;

   bit            gaps_on = 1'b1;
   bit            hold_request = 1'b0;
   post_mode_type cur_mode = MODE_NONE;
   logic [7:0]    reply_bytes[$];
   int            words_sent = 0;
   int            replies_sent = 0;
   int            settings_used = 0;

   reply_decimal_field_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   reply_field_checker field_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .replies_in_flight (replies_in_flight),
      .mismatches        (mismatches),
      .checked           (checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL reply_decimal_field_parser_unit");
      $finish;
   end

   initial begin : receiver
      int pause;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         pause = gaps_on ? $urandom_range(0, 6) : 0;
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      int pause;
      pause = gaps_on ? $urandom_range(0, 6) : 0;
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_reply();
      int i;
      for (i = 0; i < reply_bytes.size(); i++)
         send_word(reply_bytes[i], i == reply_bytes.size() - 1);
      reply_bytes.delete();
      replies_sent++;
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
   endtask

   task automatic send_framed(input string s);
      add_text(s);
      reply_bytes.push_back(CH_CR);
      reply_bytes.push_back(CH_LF);
      send_reply();
   endtask

   // idle the sender until every result is back, then let the unit settle
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (replies_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [VAL_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input int fd, input int lo, input int hi, input bit na_ok,
                            input post_mode_type mode);
      write_reg(CSR_FRACTION_DIGITS, VAL_W'(fd));
      write_reg(CSR_MIN_VALUE, lo[VAL_W-1:0]);
      write_reg(CSR_MAX_VALUE, hi[VAL_W-1:0]);
      write_reg(CSR_NA_ALLOWED, VAL_W'(na_ok));
      write_reg(CSR_POST_MODE, VAL_W'(mode));
      csr_we <= 1'b0;
      cur_mode = mode;
      settings_used++;
   endtask

   task automatic random_reply();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         n = $urandom_range(0, 9);
         if (n < 2) reply_bytes.push_back(CH_MINUS);
         else if (n == 2) reply_bytes.push_back(CH_PLUS);
         n = ($urandom_range(0, 11) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
         repeat (n) reply_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
         if ($urandom_range(0, 1) == 1) begin
            reply_bytes.push_back(CH_POINT);
            repeat ($urandom_range(0, 6))
               reply_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
         end
         if (cur_mode == MODE_MINSEC && $urandom_range(0, 9) != 0) begin
            reply_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 3))
               reply_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
         end
         if ($urandom_range(0, 9) == 0)
            reply_bytes[$urandom_range(0, reply_bytes.size() - 1)] =
               8'($urandom_range(CH_SPACE, CH_TILDE));
      end else if (kind < 72) begin
         case ($urandom_range(0, 7))
            0: add_text("NA");
            1: add_text("na");
            2: add_text("N/A");
            3: add_text("n/a");
            4: add_text("nA");
            5: add_text("N/B");
            6: add_text("N/");
            default: add_text("NaN");
         endcase
      end else if (kind < 82) begin
         repeat ($urandom_range(0, 17))
            reply_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 6)) reply_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         // payload length around the limit
         n = $urandom_range(14, 16);
         repeat (n - 1) reply_bytes.push_back(CH_ZERO);
         reply_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      n = $urandom_range(0, 19);
      if (n < 16) begin
         reply_bytes.push_back(CH_CR);
         reply_bytes.push_back(CH_LF);
      end else if (n == 16) begin
         reply_bytes.push_back(CH_CR);
      end else if (n == 17) begin
         reply_bytes.push_back(CH_LF);
         reply_bytes.push_back(CH_CR);
      end else if (n == 18) begin
         reply_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (reply_bytes.size() == 0) reply_bytes.push_back(CH_LF);
      send_reply();
   endtask

   initial begin : stimulus
      int phase;
      int fd;
      int lo;
      int hi;
      bit na_ok;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults
      send_framed("12.34");
      send_framed("655.35");
      send_framed("-0.5");
      send_framed("+7");
      send_framed("N/A");
      send_framed("na");
      send_framed("1.");
      send_framed(".5");
      send_framed("");
      send_framed("99999999");
      send_framed("000000000000001");
      send_framed("0000000000000001");
      reply_bytes.push_back(8'h00);
      send_framed("");
      reply_bytes.push_back(8'hFF);
      send_framed("");
      add_text("7");
      reply_bytes.push_back(CH_LF);
      send_reply();
      send_word(8'hFF, 1'b1);
      replies_sent++;

      phase = 0;
      while (words_sent < WORD_TARGET) begin
         drain_replies();
         fd = (phase < 5) ? phase : (($urandom_range(0, 7) == 0) ? 7 : $urandom_range(0, 4));
         case (phase % 3)
            0: begin
               lo = -65536;
               hi = 65535;
            end
            1: begin
               lo = int'($urandom_range(0, 4000)) - 2000;
               hi = lo + int'($urandom_range(0, 60000));
               if (hi > 65535) hi = 65535;
            end
            default: begin
               lo = 0;
               hi = 65535;
            end
         endcase
         na_ok = (phase == 0) ? 1'b1 : ((phase == 1) ? 1'b0 : bit'($urandom_range(0, 1)));
         configure(fd, lo, hi, na_ok, post_mode_type'(phase % 4));
         gaps_on = (phase % 3 != 1);
         if (phase == 2) hold_request = 1'b1;
         repeat (12) random_reply();
         phase++;
      end
      drain_replies();

      $display("Run covered %0d reply words in %0d replies under %0d register settings,",
               words_sent, replies_sent, settings_used);
      $display("all four post modes with stalls on both sides; %0d results compared.",
               checked);
      if (mismatches == 0) begin
         $display("PASS reply_decimal_field_parser_unit");
      end else begin
         $display("FAIL reply_decimal_field_parser_unit");
      end
      $finish;
   end

endmodule
